>>> rtl/camera_euler_rotation_update_assert.svh
// assertion macros for the camera rotation block
`ifndef CAMERA_EULER_ROTATION_UPDATE_ASSERT_SVH
`define CAMERA_EULER_ROTATION_UPDATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CER_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CER_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cer_pkg.sv
// types, constants and tables shared by the camera rotation block
`default_nettype none
package cer_pkg;

   localparam int OPW = 33;
   localparam int QF  = 30;
   localparam int PW  = 2 * OPW - QF;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam int     ATAN_STEPS  = 24;

   typedef enum logic [2:0] {
      SRC_SA  = 3'd0,
      SRC_CA  = 3'd1,
      SRC_SB  = 3'd2,
      SRC_CB  = 3'd3,
      SRC_SG  = 3'd4,
      SRC_CG  = 3'd5,
      SRC_TMP = 3'd6,
      SRC_ONE = 3'd7
   } src_type;

   typedef enum logic [2:0] {
      MD_TEMP = 3'd0,
      MD_SET  = 3'd1,
      MD_NEG  = 3'd2,
      MD_ADD  = 3'd3,
      MD_SUB  = 3'd4
   } mode_type;

   typedef struct packed {
      src_type    src_a;
      src_type    src_b;
      mode_type   mode;
      logic [3:0] dst;
   } step_type;

   localparam int NSTEPS = 17;

   // rotation matrix build program, dst is row*3+col
   function automatic step_type cer_step(input logic [4:0] n);
      step_type s;
      s = '{SRC_ONE, SRC_ONE, MD_TEMP, 4'd0};
      unique case (n)
         5'd0:  s = '{SRC_CG, SRC_SA, MD_TEMP, 4'd0};
         5'd1:  s = '{SRC_CA, SRC_SG, MD_SET,  4'd3};
         5'd2:  s = '{SRC_TMP, SRC_SB, MD_ADD, 4'd3};
         5'd3:  s = '{SRC_SA, SRC_SB, MD_TEMP, 4'd0};
         5'd4:  s = '{SRC_CA, SRC_CG, MD_SET,  4'd4};
         5'd5:  s = '{SRC_TMP, SRC_SG, MD_SUB, 4'd4};
         5'd6:  s = '{SRC_CA, SRC_CG, MD_TEMP, 4'd0};
         5'd7:  s = '{SRC_SA, SRC_SG, MD_SET,  4'd6};
         5'd8:  s = '{SRC_TMP, SRC_SB, MD_SUB, 4'd6};
         5'd9:  s = '{SRC_CA, SRC_SB, MD_TEMP, 4'd0};
         5'd10: s = '{SRC_CG, SRC_SA, MD_SET,  4'd7};
         5'd11: s = '{SRC_TMP, SRC_SG, MD_ADD, 4'd7};
         5'd12: s = '{SRC_CB, SRC_CG, MD_SET,  4'd0};
         5'd13: s = '{SRC_CB, SRC_SG, MD_NEG,  4'd1};
         5'd14: s = '{SRC_CB, SRC_SA, MD_NEG,  4'd5};
         5'd15: s = '{SRC_CA, SRC_CB, MD_SET,  4'd8};
         5'd16: s = '{SRC_SB, SRC_ONE, MD_SET, 4'd2};
         default: s = '{SRC_ONE, SRC_ONE, MD_TEMP, 4'd0};
      endcase
      return s;
   endfunction

   // truncated arctangent table, Q30
   function automatic logic [29:0] cer_atan(input logic [4:0] i);
      logic [29:0] v;
      v = '0;
      unique case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // position row*4+col of the nth upper 3x3 entry
   function automatic logic [3:0] cer_inv_pos(input logic [3:0] f);
      logic [1:0] i;
      logic [3:0] j;
      i = (f >= 4'd6) ? 2'd2 : ((f >= 4'd3) ? 2'd1 : 2'd0);
      j = f - 4'({i, 1'b0}) - 4'(i);
      return {i, j[1:0]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/camera_euler_rotation_update.sv
// camera matrix rotation update, top level
`default_nettype none
// An item is taken only while the block is idle. A restore item spends almost all its
// time emitting the 32 words. A rotate item reduces each angle by repeated subtraction
// of two pi, runs min(TRIG_ITERATIONS,24) CORDIC steps per angle, then uses the one
// shared multiplier for 17 rotation terms and 63 matrix terms, each through a multiply
// state and a write-back state, and finally emits the 32 words. Words come out as the
// camera matrix then its inverse, each row-major, with last on the final word.
module camera_euler_rotation_update
   import cer_pkg::*;
#(
   parameter int MATRIX_FRAC_BITS = 16,
   parameter int ANGLE_FRAC_BITS  = 13,
   parameter int TRIG_ITERATIONS  = 16
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic signed [15:0] req_angle_x,
   input  wire logic signed [15:0] req_angle_y,
   input  wire logic signed [15:0] req_angle_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_which_matrix,
   output logic [1:0]              rsp_row,
   output logic [1:0]              rsp_col,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_last
);

   localparam int SH   = 30 - ANGLE_FRAC_BITS;
   localparam int RW   = (16 + SH + 2 > 35) ? 16 + SH + 2 : 35;
   localparam int NIT  = (TRIG_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : TRIG_ITERATIONS;
   localparam int AW   = PW + 2;
   localparam logic signed [31:0] M_ONE  = 32'sd1 <<< MATRIX_FRAC_BITS;
   localparam logic signed [31:0] M_NEG  = -M_ONE;
   localparam logic signed [31:0] M_NEG3 = M_NEG + M_NEG + M_NEG;
   localparam logic signed [RW-1:0] R_PI   = RW'(PI_Q30);
   localparam logic signed [RW-1:0] R_2PI  = RW'(TWO_PI_Q30);
   localparam logic signed [RW-1:0] R_HPI  = RW'(HALF_PI_Q30);
   localparam logic signed [OPW-1:0] X_GAIN = OPW'(GAIN_Q30);
   localparam logic signed [OPW-1:0] X_ONE  = OPW'(ONE_Q30);
   localparam logic signed [AW-1:0] A_MAX  = AW'(64'sd2147483647);
   localparam logic signed [AW-1:0] A_MIN  = AW'(-64'sd2147483648);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_LOAD   = 10'b0000000010,
      ST_REDUCE = 10'b0000000100,
      ST_FOLD   = 10'b0000001000,
      ST_CORDIC = 10'b0000010000,
      ST_RMUL   = 10'b0000100000,
      ST_RWB    = 10'b0001000000,
      ST_MMUL   = 10'b0010000000,
      ST_MWB    = 10'b0100000000,
      ST_EMIT   = 10'b1000000000
   } state_type;

   function automatic logic signed [31:0] def_val(input logic [3:0] idx);
      logic signed [31:0] v;
      v = '0;
      if (idx == 4'd0 || idx == 4'd5 || idx == 4'd15) v = M_ONE;
      if (idx == 4'd10) v = M_NEG;
      if (idx == 4'd14) v = M_NEG3;
      return v;
   endfunction

   state_type                 state_ff;
   logic signed [31:0]        mat_ff [2][16];
   logic signed [31:0]        stage_ff [21];
   logic signed [15:0]        ang_ff [3];
   logic [1:0]                q_ff;
   logic signed [RW-1:0]      r_ff;
   logic                      flip_ff;
   logic signed [OPW-1:0]     x_ff;
   logic signed [OPW-1:0]     y_ff;
   logic [4:0]                it_ff;
   logic signed [OPW-1:0]     trig_ff [6];
   logic signed [OPW-1:0]     rot_ff [9];
   logic signed [OPW-1:0]     tmp_ff;
   logic [4:0]                step_ff;
   logic [4:0]                e_ff;
   logic [1:0]                k_ff;
   logic signed [AW-1:0]      acc_ff;
   logic [4:0]                o_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_which_ff;
   logic [1:0]                rsp_row_ff;
   logic [1:0]                rsp_col_ff;
   logic signed [31:0]        rsp_value_ff;
   logic                      rsp_last_ff;

   step_type                  cur_step;
   logic signed [OPW-1:0]     mul_a;
   logic signed [OPW-1:0]     mul_b;
   logic signed [PW-1:0]      prod;
   logic signed [OPW-1:0]     prod_n;
   logic [3:0]                f_idx;
   logic [3:0]                inv_pos;
   logic [1:0]                mi;
   logic [1:0]                mj;
   logic [3:0]                rot_idx;
   logic [3:0]                mat_idx;
   logic                      mat_sel;
   logic signed [AW-1:0]      acc_in;
   logic signed [31:0]        sat_val;
   logic signed [RW-1:0]      ang_ext;
   logic signed [RW-1:0]      atan_ext;
   logic                      out_free;

   function automatic logic signed [OPW-1:0] pick(input src_type s,
                                                  input logic signed [OPW-1:0] t [6],
                                                  input logic signed [OPW-1:0] tv);
      logic signed [OPW-1:0] v;
      v = X_ONE;
      unique case (s)
         SRC_SA:  v = t[0];
         SRC_CA:  v = t[1];
         SRC_SB:  v = t[2];
         SRC_CB:  v = t[3];
         SRC_SG:  v = t[4];
         SRC_CG:  v = t[5];
         SRC_TMP: v = tv;
         SRC_ONE: v = X_ONE;
         default: v = X_ONE;
      endcase
      return v;
   endfunction

   assign cur_step = cer_step(step_ff);
   assign f_idx    = 4'(e_ff - 5'd12);
   assign inv_pos  = cer_inv_pos(f_idx);

   always_comb begin
      if (e_ff < 5'd12) begin
         mi      = e_ff[3:2];
         mj      = e_ff[1:0];
         rot_idx = 4'({mi, 1'b0}) + 4'(mi) + 4'(k_ff);
         mat_sel = 1'b0;
         mat_idx = {k_ff, mj};
      end else begin
         mi      = inv_pos[3:2];
         mj      = inv_pos[1:0];
         rot_idx = 4'({mj, 1'b0}) + 4'(mj) + 4'(k_ff);
         mat_sel = 1'b1;
         mat_idx = {mi, k_ff};
      end
   end

   always_comb begin
      if (state_ff == ST_MMUL) begin
         mul_a = rot_ff[rot_idx];
         mul_b = OPW'(mat_ff[mat_sel][mat_idx]);
      end else begin
         mul_a = pick(cur_step.src_a, trig_ff, tmp_ff);
         mul_b = pick(cur_step.src_b, trig_ff, tmp_ff);
      end
   end

   cer_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   assign prod_n   = OPW'(prod);
   assign acc_in   = ((k_ff == 2'd0) ? '0 : acc_ff) + AW'(prod);
   assign sat_val  = (acc_in > A_MAX) ? 32'sh7fffffff :
                     ((acc_in < A_MIN) ? 32'sh80000000 : acc_in[31:0]);
   assign ang_ext  = RW'(ang_ff[q_ff]) <<< SH;
   assign atan_ext = RW'({1'b0, cer_atan(it_ff)});
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 16; n++) begin
            mat_ff[0][n] <= def_val(4'(n));
            mat_ff[1][n] <= def_val(4'(n));
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  o_ff <= '0;
                  if (req_action) begin
                     for (int n = 0; n < 16; n++) begin
                        mat_ff[0][n] <= def_val(4'(n));
                        mat_ff[1][n] <= def_val(4'(n));
                     end
                     state_ff <= ST_EMIT;
                  end else begin
                     ang_ff[0] <= req_angle_x;
                     ang_ff[1] <= req_angle_y;
                     ang_ff[2] <= req_angle_z;
                     q_ff      <= '0;
                     state_ff  <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               r_ff     <= ang_ext;
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               priority if (r_ff > R_PI) r_ff <= r_ff - R_2PI;
               else if (r_ff < -R_PI) r_ff <= r_ff + R_2PI;
               else state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               priority if (r_ff > R_HPI) begin
                  r_ff    <= R_PI - r_ff;
                  flip_ff <= 1'b1;
               end else if (r_ff < -R_HPI) begin
                  r_ff    <= -R_PI - r_ff;
                  flip_ff <= 1'b1;
               end else begin
                  flip_ff <= 1'b0;
               end
               x_ff     <= X_GAIN;
               y_ff     <= '0;
               it_ff    <= '0;
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: begin
               if (r_ff >= 0) begin
                  x_ff <= x_ff - (y_ff >>> it_ff);
                  y_ff <= y_ff + (x_ff >>> it_ff);
                  r_ff <= r_ff - atan_ext;
               end else begin
                  x_ff <= x_ff + (y_ff >>> it_ff);
                  y_ff <= y_ff - (x_ff >>> it_ff);
                  r_ff <= r_ff + atan_ext;
               end
               it_ff <= it_ff + 5'd1;
               if (it_ff == 5'(NIT - 1)) begin
                  trig_ff[{q_ff, 1'b0}] <= y_ff + (x_ff >>> it_ff)
                                           - (((r_ff >= 0) ? 0 : 2) * (x_ff >>> it_ff));
                  trig_ff[{q_ff, 1'b1}] <= flip_ff ?
                     -((r_ff >= 0) ? x_ff - (y_ff >>> it_ff) : x_ff + (y_ff >>> it_ff)) :
                      ((r_ff >= 0) ? x_ff - (y_ff >>> it_ff) : x_ff + (y_ff >>> it_ff));
                  if (q_ff == 2'd2) begin
                     step_ff  <= '0;
                     state_ff <= ST_RMUL;
                  end else begin
                     q_ff     <= q_ff + 2'd1;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_RMUL: state_ff <= ST_RWB;
            ST_RWB: begin
               unique case (cur_step.mode)
                  MD_TEMP: tmp_ff <= prod_n;
                  MD_SET:  rot_ff[cur_step.dst] <= prod_n;
                  MD_NEG:  rot_ff[cur_step.dst] <= -prod_n;
                  MD_ADD:  rot_ff[cur_step.dst] <= rot_ff[cur_step.dst] + prod_n;
                  MD_SUB:  rot_ff[cur_step.dst] <= rot_ff[cur_step.dst] - prod_n;
                  default: tmp_ff <= prod_n;
               endcase
               if (step_ff == 5'(NSTEPS - 1)) begin
                  e_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_MMUL;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= ST_RMUL;
               end
            end
            ST_MMUL: state_ff <= ST_MWB;
            ST_MWB: begin
               acc_ff <= acc_in;
               if (k_ff == 2'd2) begin
                  stage_ff[e_ff] <= sat_val;
                  k_ff           <= '0;
                  if (e_ff == 5'd20) begin
                     for (int n = 0; n < 12; n++) mat_ff[0][n] <= stage_ff[n];
                     for (int n = 0; n < 8; n++)
                        mat_ff[1][cer_inv_pos(4'(n))] <= stage_ff[12 + n];
                     mat_ff[1][cer_inv_pos(4'd8)] <= sat_val;
                     o_ff     <= '0;
                     state_ff <= ST_EMIT;
                  end else begin
                     e_ff     <= e_ff + 5'd1;
                     state_ff <= ST_MMUL;
                  end
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_MMUL;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_which_ff <= o_ff[4];
                  rsp_row_ff   <= o_ff[3:2];
                  rsp_col_ff   <= o_ff[1:0];
                  rsp_value_ff <= mat_ff[o_ff[4]][o_ff[3:0]];
                  rsp_last_ff  <= (o_ff == 5'd31);
                  o_ff         <= o_ff + 5'd1;
                  if (o_ff == 5'd31) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_which_matrix = rsp_which_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_col          = rsp_col_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

`include "camera_euler_rotation_update_assert.svh"

   `CER_ASSERT_NOW(a_idle_no_pending, !req_stall, !rsp_valid || rsp_last,
                   "block idle with a run still pending")
   `CER_ASSERT_NEXT(a_run_continues, rsp_valid && !rsp_stall && !rsp_last, rsp_valid,
                    "gap inside an output run")
   `CER_ASSERT_NEXT(a_run_order, rsp_valid && !rsp_stall && !rsp_last,
                    {rsp_which_matrix, rsp_row, rsp_col} ==
                    5'($past({rsp_which_matrix, rsp_row, rsp_col}) + 5'd1),
                    "output word out of order")

endmodule
`default_nettype wire

>>> rtl/cer_mul.sv
// shared signed multiplier with registered Q30 floor
`default_nettype none
module cer_mul
   import cer_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic signed [OPW-1:0] a,
   input  wire logic signed [OPW-1:0] b,
   output logic signed [PW-1:0]       p
);

   logic signed [2*OPW-1:0] prod;
   logic signed [PW-1:0]    p_ff;

   assign prod = a * b;

   always_ff @(posedge clock) begin
      p_ff <= prod[2*OPW-1:QF];
   end

   assign p = p_ff;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the camera euler rotation update block
`timescale 1ns / 1ps
`default_nettype none

class matrix_scoreboard;
   int         fails;
   logic [37:0] pending[$];
   longint     cam[4][4];
   longint     inv[4][4];

   function new();
      fails = 0;
      load_view();
   endfunction

   function void load_view();
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            cam[i][j] = (i == j) ? 65536 : 0;
            inv[i][j] = (i == j) ? 65536 : 0;
         end
      cam[2][2] = -65536;
      inv[2][2] = -65536;
      cam[3][2] = -3 * 65536;
      inv[3][2] = -3 * 65536;
   endfunction

   function longint fl(longint v, int s);
      return v >>> s;
   endfunction

   function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint qm(longint a, longint b);
      return fl(a * b, 30);
   endfunction

   function void trig(logic signed [15:0] ang, output longint s, output longint c);
      longint r, x, y, dx, dy;
      bit flip;
      longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
      r = (longint'(ang) * (64'sd1 << 17)) % cer_pkg::TWO_PI_Q30;
      flip = 0;
      x = cer_pkg::GAIN_Q30;
      y = 0;
      if (r > cer_pkg::PI_Q30) r -= cer_pkg::TWO_PI_Q30;
      if (r < -cer_pkg::PI_Q30) r += cer_pkg::TWO_PI_Q30;
      if (r > cer_pkg::HALF_PI_Q30) begin
         r = cer_pkg::PI_Q30 - r;
         flip = 1;
      end else if (r < -cer_pkg::HALF_PI_Q30) begin
         r = -cer_pkg::PI_Q30 - r;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = fl(y, i);
         dy = fl(x, i);
         if (r >= 0) begin
            x -= dx; y += dy; r -= tbl[i];
         end else begin
            x += dx; y -= dy; r += tbl[i];
         end
      end
      s = y;
      c = flip ? -x : x;
   endfunction

   function void note_item(bit action, logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] az);
      longint sa, ca, sb, cb, sg, cg, acc;
      longint rm[4][4], m[4][4], v[4][4];
      if (action) load_view();
      else begin
         trig(ax, sa, ca);
         trig(ay, sb, cb);
         trig(az, sg, cg);
         rm[0][0] = qm(cb, cg);
         rm[0][1] = -qm(cb, sg);
         rm[0][2] = sb;
         rm[1][0] = qm(ca, sg) + qm(qm(cg, sa), sb);
         rm[1][1] = qm(ca, cg) - qm(qm(sa, sb), sg);
         rm[1][2] = -qm(cb, sa);
         rm[2][0] = qm(sa, sg) - qm(qm(ca, cg), sb);
         rm[2][1] = qm(cg, sa) + qm(qm(ca, sb), sg);
         rm[2][2] = qm(ca, cb);
         for (int i = 0; i < 3; i++) begin
            rm[i][3] = 0;
            rm[3][i] = 0;
         end
         rm[3][3] = cer_pkg::ONE_Q30;
         m = cam;
         v = inv;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
               acc = 0;
               for (int k = 0; k < 4; k++) acc += fl(rm[i][k] * m[k][j], 30);
               cam[i][j] = sat(acc);
               if (i != 3 && j != 3) begin
                  acc = 0;
                  for (int k = 0; k < 4; k++) acc += fl(rm[j][k] * v[i][k], 30);
                  inv[i][j] = sat(acc);
               end
            end
      end
      for (int w = 0; w < 2; w++)
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               pending.push_back({w[0], i[1:0], j[1:0],
                  w ? inv[i][j][31:0] : cam[i][j][31:0], (w == 1 && i == 3 && j == 3)});
   endfunction

   function void check_word(logic w, logic [1:0] r, logic [1:0] c, logic [31:0] v, logic l);
      logic [37:0] got, exp;
      got = {w, r, c, v, l};
      if (pending.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
         fails++;
         return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
         $display("%0t: mismatch which/row/col/value/last expected %h actual %h",
                  $realtime, exp, got);
         fails++;
      end
   endfunction
endclass

module testbench;
   import cer_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_action = 0;
   logic signed [15:0] req_angle_x = 0, req_angle_y = 0, req_angle_z = 0;
   logic req_stall, rsp_valid, rsp_which_matrix, rsp_last;
   logic rsp_stall = 0;
   logic [1:0] rsp_row, rsp_col;
   logic signed [31:0] rsp_value;
   matrix_scoreboard board = new();
   bit calm = 0;
   int quiet = 0;

   camera_euler_rotation_update uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_which_matrix, rsp_row, rsp_col, rsp_value, rsp_last);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("testbench failed");
         $finish;
      end
   end

   // random receiver stall bursts
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = $urandom_range(1, 8);
         rsp_stall <= !calm && ($urandom_range(0, 2) == 0);
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_item(bit a, logic signed [15:0] x, y, z);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= a;
      req_angle_x <= x;
      req_angle_y <= y;
      req_angle_z <= z;
      do @(posedge clock); while (req_stall);
      board.note_item(a, x, y, z);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(0, 0, 0, 0);
      send_item(0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(0, -16'sh8000, -16'sh8000, -16'sh8000);
      send_item(1, 0, 0, 0);
      send_item(0, 12868, 0, 0);
      send_item(0, 0, 12868, 0);
      send_item(0, 0, 0, -12868);
      send_item(0, 25736, -25736, 25737);
      send_item(1, 16'sh7fff, -16'sh8000, 16'sh5555);
      send_item(0, 6434, -6434, 6435);
      send_item(0, 16'shffff, 16'sh0001, 16'shaaaa);
      drain();
      send_item(1, 0, 0, 0);
      for (k = 0; k < 230; k++) begin
         if (k == 200) calm = 1;
         if (k == 100) drain();
         send_item($urandom_range(0, 9) == 0, 16'($urandom), 16'($urandom),
                   16'($urandom));
      end
      drain();
      repeat (300) @(posedge clock);
      if (board.fails == 0 && board.pending.size() == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

`default_nettype wire
